FILE: hdl/qfmu_pkg.sv
package qfmu_pkg;

    typedef enum logic [2:0] {
        FN_UMUL = 3'd0,
        FN_SMUL = 3'd1,
        FN_UDIV = 3'd2,
        FN_SDIV = 3'd3,
        FN_SQRT = 3'd4
    } t_func;

    localparam int NCELLS = 32;

    // Token carried down the divide/sqrt chain.
    typedef struct packed {
        logic        vld;
        logic [2:0]  func;
        logic [31:0] rem;
        logic [31:0] feed;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic        neg;
        logic [31:0] mres;   // finished product, passed through
    } t_tok;

endpackage

FILE: hdl/q16_16_fixed_point_math_unit.sv
// Q16.16 math unit: multiply (rounded unsigned / floored signed), divide
// (unsigned / signed; a zero divisor gives all ones, or 1 for a negative signed dividend) and 16-bit floor sqrt.
// Fully pipelined: one operation per cycle while the output is not stalled,
// 34 register stages (one entry stage, a chain of 32 cells each resolving
// one quotient bit of a divide, one output stage). The multiply is done in
// the entry stage and rides the chain. o_stall is high only while a result
// waits in the output register under i_stall; the whole chain freezes for
// those cycles.
module q16_16_fixed_point_math_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result
);
    import qfmu_pkg::*;

    t_tok        n_in;
    t_tok        chain [0:NCELLS];
    logic [63:0] prod;
    logic [31:0] ma;
    logic [31:0] mb;
    logic        r_valid;
    logic [31:0] r_result;
    logic [31:0] n_result;
    logic        adv;
    t_tok        last;

    // Output register can refill while the taker drains it.
    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;

    always_comb begin
        prod = 64'd0;
        if (i_func == FN_SMUL)
            prod = $signed({{32{i_operand_a[31]}}, i_operand_a})
                 * $signed({{32{i_operand_b[31]}}, i_operand_b});
        else
            prod = {32'd0, i_operand_a} * {32'd0, i_operand_b} + 64'h8000;
        ma = (i_func == FN_SDIV && i_operand_a[31]) ? 32'd0 - i_operand_a : i_operand_a;
        mb = (i_func == FN_SDIV && i_operand_b[31]) ? 32'd0 - i_operand_b : i_operand_b;
        n_in      = '0;
        n_in.vld  = i_valid;
        n_in.func = i_func;
        n_in.dvs  = mb;
        n_in.neg  = (i_func == FN_SDIV) && (i_operand_a[31] ^ i_operand_b[31]);
        n_in.mres = prod[47:16];
        if (i_func == FN_SQRT) begin
            n_in.rem = {16'd0, i_operand_a[15:0]};
        end else begin
            n_in.rem  = {16'd0, ma[31:16]};
            n_in.feed = {ma[15:0], 16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            chain[0].vld <= 1'b0;
        end else if (adv) begin
            chain[0].vld <= n_in.vld;
        end
        if (adv) begin
            chain[0].func <= n_in.func;
            chain[0].rem  <= n_in.rem;
            chain[0].feed <= n_in.feed;
            chain[0].quo  <= n_in.quo;
            chain[0].dvs  <= n_in.dvs;
            chain[0].neg  <= n_in.neg;
            chain[0].mres <= n_in.mres;
        end
    end

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        qfmu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stall (!adv),
            .i_idx   (5'(g)),
            .i_tok   (chain[g]),
            .o_tok   (chain[g+1])
        );
    end

    assign last = chain[NCELLS];

    always_comb begin
        case (last.func)
            FN_UMUL, FN_SMUL: n_result = last.mres;
            FN_UDIV:          n_result = last.quo;
            FN_SDIV:          n_result = last.neg ? 32'd0 - last.quo : last.quo;
            FN_SQRT:          n_result = last.quo;
            default:          n_result = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= last.vld;
        end
        if (adv) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_result)))
        else $error("result changed under stall");
    a_nostall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> !o_stall)
        else $error("stalled with empty output");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && last.vld) |=> r_valid)
        else $error("chain beat lost");
endmodule

FILE: hdl/qfmu_cell.sv
module qfmu_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_stall,
    input  logic [4:0]     i_idx,
    input  qfmu_pkg::t_tok i_tok,
    output qfmu_pkg::t_tok o_tok
);
    import qfmu_pkg::*;

    t_tok        n_tok;
    t_tok        r_tok;
    logic [31:0] shr;
    logic [31:0] trial;
    logic [31:0] bitv;

    // Divide step: one quotient bit. Sqrt step (cells 0..7): one root bit.
    always_comb begin
        n_tok = i_tok;
        shr   = {i_tok.rem[30:0], i_tok.feed[31]};
        bitv  = 32'h4000 >> {i_idx[2:0], 1'b0};
        trial = i_tok.quo | bitv;
        if (i_tok.func == FN_UDIV || i_tok.func == FN_SDIV) begin
            n_tok.feed = {i_tok.feed[30:0], 1'b0};
            if (shr >= i_tok.dvs) begin
                n_tok.rem = shr - i_tok.dvs;
                n_tok.quo = {i_tok.quo[30:0], 1'b1};
            end else begin
                n_tok.rem = shr;
                n_tok.quo = {i_tok.quo[30:0], 1'b0};
            end
        end else if (i_tok.func == FN_SQRT && i_idx < 5'd8) begin
            n_tok.quo = i_tok.quo >> 1;
            if (i_tok.rem >= trial) begin
                n_tok.quo = (i_tok.quo >> 1) | bitv;
                n_tok.rem = i_tok.rem - trial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (!i_stall) begin
            r_tok.vld <= i_tok.vld;
        end
        if (!i_stall) begin
            r_tok.func <= n_tok.func;
            r_tok.rem  <= n_tok.rem;
            r_tok.feed <= n_tok.feed;
            r_tok.quo  <= n_tok.quo;
            r_tok.dvs  <= n_tok.dvs;
            r_tok.neg  <= n_tok.neg;
            r_tok.mres <= n_tok.mres;
        end
    end

    assign o_tok = r_tok;
endmodule
